// ===== sv/plane_point_sphere_segment_test_top_macros.svh =====
// assertion macros shared by the plane test rtl
`ifndef PLANE_POINT_SPHERE_SEGMENT_TEST_TOP_MACROS_SVH
`define PLANE_POINT_SPHERE_SEGMENT_TEST_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define PPST_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ppst assertion failed");
`define PPST_ASSERT_NEVER(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("ppst forbidden condition seen");
`else
`define PPST_ASSERT(name, clk, rst_n, prop)
`define PPST_ASSERT_NEVER(name, clk, rst_n, prop)
`endif
`endif

// ===== sv/ppst_pkg.sv =====
// shared types and constants of the plane test pipeline
`default_nettype none
package ppst_pkg;

  localparam int CoordW = 32;
  localparam int NormW  = 16;
  localparam int RadW   = 31;
  // exact dot products plus aligned offset stay below 2^50 in magnitude
  localparam int AccW   = 52;
  localparam int DataW  = 32;
  localparam int AddrW  = 4;

  localparam logic signed [NormW-1:0] NormZReset = 16'sd16384;

  typedef enum logic [1:0] {
    RegNormalX = 2'd0,
    RegNormalY = 2'd1,
    RegNormalZ = 2'd2,
    RegOffset  = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic signed [NormW-1:0]  normal_x;
    logic signed [NormW-1:0]  normal_y;
    logic signed [NormW-1:0]  normal_z;
    logic signed [CoordW-1:0] offset;
  } cfg_t;

  typedef struct packed {
    logic [2:0][CoordW-1:0] p1;
    logic [2:0][CoordW-1:0] p2;
  } pts_t;

  typedef struct packed {
    logic [CoordW-1:0] distance;
    logic [CoordW-1:0] marg;
    logic              is_inside;
    logic              touch;
  } res_t;

  typedef struct packed {
    pts_t            pts;
    res_t            res;
    logic            cand;
    logic [AccW-1:0] num;
    logic [AccW-1:0] den;
  } seg_t;

  typedef struct packed {
    pts_t pts;
    res_t res;
    logic cand;
  } carry_t;

endpackage
`default_nettype wire

// ===== sv/ppst_regs.sv =====
// apb register file holding the plane normal and offset
`default_nettype none
module ppst_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ppst_pkg::AddrW-1:0]   paddr,
  input  logic [ppst_pkg::DataW-1:0]   pwdata,
  output logic [ppst_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  output ppst_pkg::cfg_t               cfg_o
);

  ppst_pkg::cfg_t     cfg_q;
  ppst_pkg::reg_idx_e idx;

  assign idx    = ppst_pkg::reg_idx_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.normal_x <= '0;
      cfg_q.normal_y <= '0;
      cfg_q.normal_z <= ppst_pkg::NormZReset;
      cfg_q.offset   <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        ppst_pkg::RegNormalX: cfg_q.normal_x <= pwdata[ppst_pkg::NormW-1:0];
        ppst_pkg::RegNormalY: cfg_q.normal_y <= pwdata[ppst_pkg::NormW-1:0];
        ppst_pkg::RegNormalZ: cfg_q.normal_z <= pwdata[ppst_pkg::NormW-1:0];
        ppst_pkg::RegOffset:  cfg_q.offset   <= pwdata[ppst_pkg::CoordW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ppst_pkg::RegNormalX:
        prdata = {{(ppst_pkg::DataW-ppst_pkg::NormW){1'b0}}, cfg_q.normal_x};
      ppst_pkg::RegNormalY:
        prdata = {{(ppst_pkg::DataW-ppst_pkg::NormW){1'b0}}, cfg_q.normal_y};
      ppst_pkg::RegNormalZ:
        prdata = {{(ppst_pkg::DataW-ppst_pkg::NormW){1'b0}}, cfg_q.normal_z};
      ppst_pkg::RegOffset:
        prdata = cfg_q.offset;
      default:
        prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/ppst_front.sv =====
// dot products, distance, margin, flags and segment ratio set-up
`default_nettype none
`include "plane_point_sphere_segment_test_top_macros.svh"
module ppst_front #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ppst_pkg::cfg_t                cfg_i,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  ppst_pkg::pts_t                pts_i,
  input  logic [ppst_pkg::RadW-1:0]     rad_i,
  output logic                          valid_o,
  input  logic                          ready_i,
  output ppst_pkg::seg_t                seg_o
);

  localparam int AccW   = ppst_pkg::AccW;
  localparam int CoordW = ppst_pkg::CoordW;
  localparam int ProdW  = ppst_pkg::NormW + ppst_pkg::CoordW;
  localparam int NStg   = 5;

  function automatic logic [CoordW-1:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = {{(AccW-CoordW+1){1'b0}}, {(CoordW-1){1'b1}}};
    lo = {{(AccW-CoordW+1){1'b1}}, {(CoordW-1){1'b0}}};
    if (v > hi) begin
      return hi[CoordW-1:0];
    end else if (v < lo) begin
      return lo[CoordW-1:0];
    end
    return v[CoordW-1:0];
  endfunction

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] load;

  logic signed [ppst_pkg::NormW-1:0] nrm [3];
  logic signed [AccW-1:0]            dalign;

  // stage 1
  logic signed [ProdW-1:0]       prod_q [6];
  ppst_pkg::pts_t                pts1_q;
  logic [ppst_pkg::RadW-1:0]     rad1_q;
  // stage 2
  logic signed [AccW-1:0]        i0_q, i1_q;
  ppst_pkg::pts_t                pts2_q;
  logic [ppst_pkg::RadW-1:0]     rad2_q;
  // stage 3
  logic signed [AccW-1:0]        dist_q, marg_q, num3_q, den3_q, rad_s3;
  ppst_pkg::pts_t                pts3_q;
  logic [ppst_pkg::RadW-1:0]     rad3_q;
  logic signed [AccW-1:0]        rad_s2;
  // stage 4
  ppst_pkg::res_t                res4_q;
  logic [AccW-1:0]               num4_q, den4_q;
  ppst_pkg::pts_t                pts4_q;
  // stage 5
  ppst_pkg::seg_t                seg_q;

  assign nrm[0] = cfg_i.normal_x;
  assign nrm[1] = cfg_i.normal_y;
  assign nrm[2] = cfg_i.normal_z;
  assign dalign = AccW'(cfg_i.offset) <<< NORMAL_FRAC_BITS;
  assign rad_s2 = AccW'($signed({1'b0, rad2_q})) <<< NORMAL_FRAC_BITS;
  assign rad_s3 = AccW'($signed({1'b0, rad3_q})) <<< NORMAL_FRAC_BITS;

  always_comb begin
    load[NStg-1] = !v_q[NStg-1] || ready_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      load[k] = !v_q[k] || load[k+1];
    end
  end

  assign ready_o = load[0];
  assign valid_o = v_q[NStg-1];
  assign seg_o   = seg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (load[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (load[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k]   <= nrm[k] * $signed(pts_i.p1[k]);
        prod_q[k+3] <= nrm[k] * $signed(pts_i.p2[k]);
      end
      pts1_q <= pts_i;
      rad1_q <= rad_i;
    end
    if (load[1]) begin
      i0_q   <= AccW'(prod_q[0]) + AccW'(prod_q[1]) + AccW'(prod_q[2]);
      i1_q   <= AccW'(prod_q[3]) + AccW'(prod_q[4]) + AccW'(prod_q[5]);
      pts2_q <= pts1_q;
      rad2_q <= rad1_q;
    end
    if (load[2]) begin
      dist_q <= i0_q + dalign;
      marg_q <= i0_q + dalign - rad_s2;
      num3_q <= -i1_q - dalign;
      den3_q <= i0_q - i1_q;
      pts3_q <= pts2_q;
      rad3_q <= rad2_q;
    end
    if (load[3]) begin
      res4_q.distance  <= sat32(dist_q >>> NORMAL_FRAC_BITS);
      res4_q.marg      <= sat32(marg_q >>> NORMAL_FRAC_BITS);
      res4_q.is_inside <= dist_q <= 0;
      res4_q.touch     <= (dist_q + rad_s3) > 0;
      if (den3_q < 0) begin
        num4_q <= -num3_q;
        den4_q <= -den3_q;
      end else begin
        num4_q <= num3_q;
        den4_q <= den3_q;
      end
      pts4_q <= pts3_q;
    end
    if (load[4]) begin
      seg_q.pts  <= pts4_q;
      seg_q.res  <= res4_q;
      seg_q.num  <= num4_q;
      seg_q.den  <= den4_q;
      seg_q.cand <= (den4_q != '0) && ($signed(num4_q) > 0) &&
                    ($signed(num4_q) < $signed(den4_q));
    end
  end

  `PPST_ASSERT(a_cand_ratio, clk_i, rst_ni, v_q[NStg-1] && seg_q.cand |-> seg_q.num < seg_q.den)

endmodule
`default_nettype wire

// ===== sv/ppst_div.sv =====
// restoring divider, one quotient bit per pipeline stage
`default_nettype none
`include "plane_point_sphere_segment_test_top_macros.svh"
module ppst_div #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    ready_o,
  input  ppst_pkg::seg_t          seg_i,
  output logic                    valid_o,
  input  logic                    ready_i,
  output ppst_pkg::carry_t        car_o,
  output logic [T_FRAC_BITS-1:0]  t_o
);

  localparam int AccW = ppst_pkg::AccW;
  localparam int T    = T_FRAC_BITS;

  logic [T-1:0]          v_q;
  logic [T-1:0]          load;
  logic [AccW-1:0]       r_q   [T];
  logic [AccW-1:0]       den_q [T];
  logic [T-1:0]          t_q   [T];
  ppst_pkg::carry_t      car_q [T];

  always_comb begin
    load[T-1] = !v_q[T-1] || ready_i;
    for (int k = T - 2; k >= 0; k--) begin
      load[k] = !v_q[k] || load[k+1];
    end
  end

  assign ready_o = load[0];
  assign valid_o = v_q[T-1];
  assign car_o   = car_q[T-1];
  assign t_o     = t_q[T-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (load[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < T; k++) begin
        if (load[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  for (genvar g = 0; g < T; g++) begin : g_step
    logic [AccW-1:0]  r_in;
    logic [AccW-1:0]  den_in;
    logic [T-1:0]     t_in;
    ppst_pkg::carry_t c_in;
    logic [AccW-1:0]  r2;
    logic             ge;

    if (g == 0) begin : g_first
      assign r_in     = seg_i.num;
      assign den_in   = seg_i.den;
      assign t_in     = '0;
      assign c_in.pts  = seg_i.pts;
      assign c_in.res  = seg_i.res;
      assign c_in.cand = seg_i.cand;
    end else begin : g_next
      assign r_in   = r_q[g-1];
      assign den_in = den_q[g-1];
      assign t_in   = t_q[g-1];
      assign c_in   = car_q[g-1];
    end

    assign r2 = {r_in[AccW-2:0], 1'b0};
    assign ge = r2 >= den_in;

    always_ff @(posedge clk_i) begin
      if (load[g]) begin
        r_q[g]   <= ge ? (r2 - den_in) : r2;
        t_q[g]   <= {t_in[T-2:0], ge};
        den_q[g] <= den_in;
        car_q[g] <= c_in;
      end
    end
  end

  `PPST_ASSERT(a_rem_below_den, clk_i, rst_ni, v_q[T-1] && car_q[T-1].cand |-> r_q[T-1] < den_q[T-1])

endmodule
`default_nettype wire

// ===== sv/ppst_lerp.sv =====
// crossing point p2 + (p1 - p2) * t and output register
`default_nettype none
`include "plane_point_sphere_segment_test_top_macros.svh"
module ppst_lerp #(
  parameter int T_FRAC_BITS = 16
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 valid_i,
  output logic                                 ready_o,
  input  ppst_pkg::carry_t                     car_i,
  input  logic [T_FRAC_BITS-1:0]               t_i,
  output logic                                 valid_o,
  input  logic                                 ready_i,
  output ppst_pkg::res_t                       res_o,
  output logic                                 hit_o,
  output logic [2:0][ppst_pkg::CoordW-1:0]     hit_pt_o
);

  localparam int CoordW = ppst_pkg::CoordW;
  localparam int ProdW  = CoordW + T_FRAC_BITS + 2;
  localparam int NStg   = 3;

  logic [NStg-1:0] v_q;
  logic [NStg-1:0] load;

  // stage 1
  logic signed [CoordW:0]    diff_q [3];
  logic [T_FRAC_BITS-1:0]    t1_q;
  logic [2:0][CoordW-1:0]    p2a_q;
  logic                      cand1_q;
  ppst_pkg::res_t            res1_q;
  // stage 2
  logic signed [ProdW-1:0]   prod_q [3];
  logic [2:0][CoordW-1:0]    p2b_q;
  logic                      cand2_q;
  ppst_pkg::res_t            res2_q;
  // stage 3
  logic [2:0][CoordW-1:0]    hp_q;
  logic                      hit_q;
  ppst_pkg::res_t            res_q;

  logic signed [ProdW-1:0]   sh [3];

  always_comb begin
    load[NStg-1] = !v_q[NStg-1] || ready_i;
    for (int k = NStg - 2; k >= 0; k--) begin
      load[k] = !v_q[k] || load[k+1];
    end
    for (int k = 0; k < 3; k++) begin
      sh[k] = prod_q[k] >>> T_FRAC_BITS;
    end
  end

  assign ready_o  = load[0];
  assign valid_o  = v_q[NStg-1];
  assign res_o    = res_q;
  assign hit_o    = hit_q;
  assign hit_pt_o = hp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (load[0]) begin
        v_q[0] <= valid_i;
      end
      for (int k = 1; k < NStg; k++) begin
        if (load[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      for (int k = 0; k < 3; k++) begin
        diff_q[k] <= (CoordW+1)'($signed(car_i.pts.p1[k])) -
                     (CoordW+1)'($signed(car_i.pts.p2[k]));
      end
      t1_q    <= t_i;
      p2a_q   <= car_i.pts.p2;
      cand1_q <= car_i.cand;
      res1_q  <= car_i.res;
    end
    if (load[1]) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k] <= diff_q[k] * $signed({1'b0, t1_q});
      end
      p2b_q   <= p2a_q;
      cand2_q <= cand1_q;
      res2_q  <= res1_q;
    end
    if (load[2]) begin
      for (int k = 0; k < 3; k++) begin
        hp_q[k] <= cand2_q ? (sh[k][CoordW-1:0] + p2b_q[k]) : '0;
      end
      hit_q <= cand2_q;
      res_q <= res2_q;
    end
  end

  `PPST_ASSERT_NEVER(a_no_hit_zero, clk_i, rst_ni, v_q[NStg-1] && !hit_q && (hp_q != '0))

endmodule
`default_nettype wire

// ===== sv/plane_point_sphere_segment_test_top.sv =====
// top level of the plane point, sphere and segment test pipeline
`default_nettype none
`include "plane_point_sphere_segment_test_top_macros.svh"
// Accepts one request per clock while in_ready_o is high and returns one result
// per request, in order. It has five stages of dot product, distance and flag
// logic, one restoring divider stage per bit of the segment ratio t, and three
// stages for the crossing point multiply and output register. Stalls at the
// output are absorbed by empty pipeline slots first. The plane registers sit on
// the apb port; write them only while idle, which the block does not enforce.
module plane_point_sphere_segment_test_top #(
  parameter int NORMAL_FRAC_BITS = 14,
  parameter int T_FRAC_BITS      = 16
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [ppst_pkg::AddrW-1:0]         paddr,
  input  logic [ppst_pkg::DataW-1:0]         pwdata,
  output logic [ppst_pkg::DataW-1:0]         prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [ppst_pkg::CoordW-1:0] first_x_i,
  input  logic signed [ppst_pkg::CoordW-1:0] first_y_i,
  input  logic signed [ppst_pkg::CoordW-1:0] first_z_i,
  input  logic signed [ppst_pkg::CoordW-1:0] second_x_i,
  input  logic signed [ppst_pkg::CoordW-1:0] second_y_i,
  input  logic signed [ppst_pkg::CoordW-1:0] second_z_i,
  input  logic [ppst_pkg::RadW-1:0]          radius_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [ppst_pkg::CoordW-1:0] signed_distance_o,
  output logic signed [ppst_pkg::CoordW-1:0] sphere_margin_o,
  output logic                               point_inside_o,
  output logic                               sphere_touching_o,
  output logic                               hit_o,
  output logic signed [ppst_pkg::CoordW-1:0] hit_x_o,
  output logic signed [ppst_pkg::CoordW-1:0] hit_y_o,
  output logic signed [ppst_pkg::CoordW-1:0] hit_z_o
);

  ppst_pkg::cfg_t   cfg;
  ppst_pkg::pts_t   pts;
  ppst_pkg::seg_t   seg;
  ppst_pkg::carry_t car;
  ppst_pkg::res_t   res;
  logic             seg_valid, seg_ready;
  logic             div_valid, div_ready;
  logic [T_FRAC_BITS-1:0]                t_val;
  logic [2:0][ppst_pkg::CoordW-1:0]      hit_pt;

  assign pts.p1[0] = first_x_i;
  assign pts.p1[1] = first_y_i;
  assign pts.p1[2] = first_z_i;
  assign pts.p2[0] = second_x_i;
  assign pts.p2[1] = second_y_i;
  assign pts.p2[2] = second_z_i;

  ppst_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ppst_front #(
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .pts_i   (pts),
    .rad_i   (radius_i),
    .valid_o (seg_valid),
    .ready_i (seg_ready),
    .seg_o   (seg)
  );

  ppst_div #(
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (seg_valid),
    .ready_o (seg_ready),
    .seg_i   (seg),
    .valid_o (div_valid),
    .ready_i (div_ready),
    .car_o   (car),
    .t_o     (t_val)
  );

  ppst_lerp #(
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_lerp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (div_valid),
    .ready_o  (div_ready),
    .car_i    (car),
    .t_i      (t_val),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .res_o    (res),
    .hit_o    (hit_o),
    .hit_pt_o (hit_pt)
  );

  assign signed_distance_o = res.distance;
  assign sphere_margin_o   = res.marg;
  assign point_inside_o    = res.is_inside;
  assign sphere_touching_o = res.touch;
  assign hit_x_o           = hit_pt[0];
  assign hit_y_o           = hit_pt[1];
  assign hit_z_o           = hit_pt[2];

  `PPST_ASSERT(a_idle_out_takes_request, clk_i, rst_ni, !out_valid_o |-> in_ready_o)

endmodule
`default_nettype wire
